// ===== design/swf_pkg.sv =====
// Shared widths, angle constants and register indexes of the swath window finder.
package swf_pkg;

	localparam int ANGLE_W      = 16;
	localparam int STAMP_W      = 63;
	localparam int CFG_W        = 18;
	localparam int IN_TDATA_W   = 80;
	localparam int OUT_TDATA_W  = 128;
	localparam int MIN_RECORDS  = 10;
	localparam int DIR_LOOKBACK = 10;

	typedef logic signed [20:0] ang_t;
	typedef logic signed [31:0] acc_t;
	typedef logic [STAMP_W-1:0] stamp_t;

	localparam ang_t ANG_HALF_PI = 21'sd16384;
	localparam ang_t ANG_PI      = 21'sd32768;
	localparam ang_t ANG_TWO_PI  = 21'sd65536;

	localparam logic REG_MAX_ANGLE = 1'b0;
	localparam logic REG_MIN_ANGLE = 1'b1;

endpackage

// ===== design/swath_window_finder.sv =====
// Top level of the swath window finder: record ring memories and the query walker.
//
// Input stream (s_axis): tuser = op, 0 pushes a record, 1 queries the latest swath.
// A push word writes one ring record, taken once per cycle while idle and not held off.
// A query word produces exactly one result word on m_axis: tuser = found,
// tdata = start_time and end_time (zero when nothing was found).
// With fewer than ten records the result is registered in the cycle after the query.
// Otherwise the query reads the newest and the direction record in ST_RDA to ST_DIR,
// then walks the ring from newest to oldest one record per cycle through the single
// read port of the ring memories and the s1 and s2 pipeline registers, ending early
// once the swath is complete.
// No input word is taken while a query walks.
// The result sits in an output register; a held result blocks only a new word
// when the receiver does not take it in the same cycle.
// Configuration (cfg_*) is always ready; index 0 writes the upper and index 1 the
// lower swath angle. Write it only while the block is idle.
// Reset empties the ring (count and write slot to zero) and clears both angles;
// the ring memories need no clearing pass since only written entries are read.
module swath_window_finder
	import swf_pkg::*;
#(
	parameter int HISTORY_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sensor_angle[15:0], stamp[78:16], zero pad
	input  logic                   s_axis_tuser,   // op
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // start_time[62:0], end_time[125:63], zero pad
	output logic                   m_axis_tuser,   // found
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDA  = 3'd1;
	localparam logic [2:0] ST_RDB  = 3'd2;
	localparam logic [2:0] ST_DIR  = 3'd3;
	localparam logic [2:0] ST_WALK = 3'd4;

	localparam logic [1:0] PH_SEEK_POS = 2'd0;
	localparam logic [1:0] PH_SEEK_NEG = 2'd1;
	localparam logic [1:0] PH_ACCUM    = 2'd2;

	logic [ANGLE_W-1:0] angle_mem [HISTORY_DEPTH];
	stamp_t             stamp_mem [HISTORY_DEPTH];

	logic [2:0]              state_q;
	logic [AW-1:0]           wslot_q;
	logic [CW-1:0]           count_q;
	logic signed [CFG_W-1:0] max_cfg_q;
	logic signed [CFG_W-1:0] min_cfg_q;

	logic [ANGLE_W-1:0] init_q;
	logic               inc_q;
	ang_t               max_a_q;
	ang_t               range_q;
	logic [AW-1:0]      walk_ptr_q;
	logic [CW-1:0]      issue_k_q;

	logic [ANGLE_W-1:0] ang_rd_s1;
	stamp_t             stamp_rd_s1;
	logic               v_s1;
	logic               last_s1;
	ang_t               a_s2;
	stamp_t             stamp_s2;
	logic               v_s2;
	logic               last_s2;

	logic [1:0] phase_q;
	ang_t       prev_q;
	acc_t       accum_q;
	stamp_t     tstart_q;
	stamp_t     tend_q;

	logic                   out_valid_q;
	logic                   out_found_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic          in_acc;
	logic          is_query;
	logic [AW-1:0] newest;
	logic [AW-1:0] newest_prev;
	logic [AW-1:0] walk_prev;
	logic [AW:0]   look_w;
	logic [AW:0]   look_sum;
	logic [AW-1:0] look_slot;
	logic [AW-1:0] rd_addr;
	logic          issue;
	ang_t          fa;
	ang_t          mx;
	ang_t          d;
	acc_t          acc_n;
	logic          found_now;
	logic          fin;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign is_query      = s_axis_tuser;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		newest      = (wslot_q == '0) ? AW'(HISTORY_DEPTH - 1) : wslot_q - AW'(1);
		newest_prev = (newest == '0) ? AW'(HISTORY_DEPTH - 1) : newest - AW'(1);
		walk_prev   = (walk_ptr_q == '0) ? AW'(HISTORY_DEPTH - 1) : walk_ptr_q - AW'(1);
		look_w      = (count_q > CW'(DIR_LOOKBACK)) ? (AW+1)'(DIR_LOOKBACK)
		                                            : (AW+1)'(count_q - CW'(1));
		look_sum    = {1'b0, newest} + (AW+1)'(HISTORY_DEPTH) - look_w;
		if (look_sum >= (AW+1)'(HISTORY_DEPTH)) begin
			look_sum = look_sum - (AW+1)'(HISTORY_DEPTH);
		end
		look_slot = look_sum[AW-1:0];
		case (state_q)
			ST_RDA:  rd_addr = newest;
			ST_RDB:  rd_addr = look_slot;
			ST_DIR:  rd_addr = newest;
			ST_WALK: rd_addr = walk_ptr_q;
			default: rd_addr = newest;
		endcase
		issue = (state_q == ST_WALK) && (issue_k_q < count_q);
	end

	// fold the angle read back from the ring
	always_comb begin
		fa = ang_t'({5'd0, ang_rd_s1});
		if (!inc_q) begin
			fa = -fa;
		end
		fa = fa - max_a_q;
		if (fa < 0) begin
			fa = fa + ANG_TWO_PI;
		end
		if (fa >= ANG_PI) begin
			fa = fa - ANG_PI;
		end
		if (fa >= ANG_HALF_PI) begin
			fa = fa - ANG_PI;
		end
	end

	always_comb begin
		mx = ang_t'(max_cfg_q);
		if (mx >= ANG_PI) begin
			mx = ang_t'({1'b0, max_cfg_q[14:0]});
		end
	end

	always_comb begin
		d = prev_q - a_s2;
		if (d > ANG_HALF_PI) begin
			d = d - ANG_PI;
		end else if (d < -ANG_HALF_PI) begin
			d = d + ANG_PI;
		end
		acc_n     = accum_q + acc_t'(d);
		found_now = v_s2 && (phase_q == PH_ACCUM) && (acc_n > acc_t'(range_q));
		fin       = (state_q == ST_WALK) && v_s2 && (found_now || last_s2);
	end

	always_ff @(posedge clk) begin
		if (in_acc && !is_query) begin
			angle_mem[wslot_q] <= s_axis_tdata[ANGLE_W-1:0];
			stamp_mem[wslot_q] <= s_axis_tdata[ANGLE_W +: STAMP_W];
		end
		ang_rd_s1   <= angle_mem[rd_addr];
		stamp_rd_s1 <= stamp_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RDB) begin
			init_q <= ang_rd_s1;
		end
		if (state_q == ST_DIR) begin
			inc_q   <= ang_rd_s1 < init_q;
			max_a_q <= mx;
			range_q <= ang_t'(max_cfg_q) - ang_t'(min_cfg_q);
		end
		a_s2     <= fa;
		stamp_s2 <= stamp_rd_s1;
		if (state_q == ST_DIR) begin
			walk_ptr_q <= newest_prev;
			issue_k_q  <= CW'(1);
		end else if (issue) begin
			walk_ptr_q <= walk_prev;
			issue_k_q  <= issue_k_q + CW'(1);
		end
		if (state_q == ST_DIR) begin
			last_s1 <= (count_q == CW'(1));
		end else begin
			last_s1 <= (issue_k_q == count_q - CW'(1));
		end
		last_s2 <= last_s1;
		if (state_q == ST_DIR) begin
			prev_q  <= '0;
			accum_q <= '0;
		end else if (v_s2 && (state_q == ST_WALK)) begin
			case (phase_q)
				PH_SEEK_NEG: begin
					if (a_s2 < 0) begin
						tstart_q <= stamp_s2;
						tend_q   <= stamp_s2;
						prev_q   <= a_s2;
					end
				end
				PH_ACCUM: begin
					if (!found_now) begin
						tstart_q <= stamp_s2;
						prev_q   <= a_s2;
						accum_q  <= acc_n;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && is_query && (count_q < CW'(MIN_RECORDS))) begin
			out_data_q <= '0;
		end else if (fin) begin
			out_data_q <= found_now ? {2'b00, tend_q, tstart_q} : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wslot_q     <= '0;
			count_q     <= '0;
			max_cfg_q   <= '0;
			min_cfg_q   <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			phase_q     <= PH_SEEK_POS;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_MAX_ANGLE: max_cfg_q <= cfg_data;
					REG_MIN_ANGLE: min_cfg_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= (state_q == ST_DIR) || issue;
			v_s2 <= v_s1 && (state_q == ST_WALK) && !fin;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && !is_query) begin
						wslot_q <= (wslot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wslot_q + AW'(1);
						if (count_q < CW'(HISTORY_DEPTH)) begin
							count_q <= count_q + CW'(1);
						end
					end else if (in_acc) begin
						if (count_q < CW'(MIN_RECORDS)) begin
							out_valid_q <= 1'b1;
							out_found_q <= 1'b0;
						end else begin
							state_q <= ST_RDA;
						end
					end
				end
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: state_q <= ST_DIR;
				ST_DIR: begin
					phase_q <= PH_SEEK_POS;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (v_s2) begin
						case (phase_q)
							PH_SEEK_POS: if (a_s2 >= 0) phase_q <= PH_SEEK_NEG;
							PH_SEEK_NEG: if (a_s2 < 0) phase_q <= PH_ACCUM;
							default: begin
							end
						endcase
					end
					if (fin) begin
						out_valid_q <= 1'b1;
						out_found_q <= found_now;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/swf_checker.sv =====
// Port-level checks of the swath window finder and their binding to the top level.
module swf_checker
	import swf_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic                   m_axis_tuser,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("result without swath carries nonzero times");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_axis_tuser |=> m_axis_tvalid || !s_axis_tready)
		else $error("query neither answered nor walking");

	a_push_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("push word produced a result");

endmodule

bind swath_window_finder swf_checker u_swf_checker (.*);
